// File: design/wfba_pkg.sv
`default_nettype none

package wfba_pkg;

  // Input word: what to do and the size that goes with it.
  typedef struct packed {
    logic        action;
    logic [15:0] amount;
  } wfba_in_t;

  // Action codes carried in the action bit.
  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    OUT_ADDED   = 2'd0,
    OUT_GRANTED = 2'd1,
    OUT_NOFIT   = 2'd2,
    OUT_FULL    = 2'd3
  } wfba_outcome_t;

  // Result word.
  typedef struct packed {
    wfba_outcome_t outcome;
    logic [4:0]    block_index;
    logic [15:0]   block_amount;
    logic [15:0]   request_number;
  } wfba_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } wfba_state_t;

endpackage

`default_nettype wire

// File: design/wfba_cell.sv
`default_nettype none

module wfba_cell #(
  parameter int IDX_W     = 5,
  parameter int SIZE_BITS = 16,
  parameter int CELL_IDX  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_en,
  input  wire logic [SIZE_BITS-1:0] load_size,
  input  wire logic                 grant_en,
  input  wire logic                 cand_found_i,
  input  wire logic [IDX_W-1:0]     cand_idx_i,
  input  wire logic [SIZE_BITS-1:0] cand_size_i,
  output logic                      cand_found_o,
  output logic [IDX_W-1:0]          cand_idx_o,
  output logic [SIZE_BITS-1:0]      cand_size_o,
  output logic                      used_o,
  output logic                      loaded_o
);

  logic                 loaded_r;
  logic                 used_r;
  logic [SIZE_BITS-1:0] size_r;
  logic                 found_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SIZE_BITS-1:0] best_r;
  logic                 take;

  // This cell replaces the incoming candidate only if it is strictly larger,
  // so the earliest loaded block wins a tie.
  assign take = loaded_r && !used_r && (!cand_found_i || (size_r > cand_size_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      used_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      if (load_en) begin
        loaded_r <= 1'b1;
        used_r   <= 1'b0;
      end else if (grant_en) begin
        used_r <= 1'b1;
      end
      found_r <= take || cand_found_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      size_r <= load_size;
    end
    if (take) begin
      idx_r  <= IDX_W'(CELL_IDX);
      best_r <= size_r;
    end else begin
      idx_r  <= cand_idx_i;
      best_r <= cand_size_i;
    end
  end

  assign cand_found_o = found_r;
  assign cand_idx_o   = idx_r;
  assign cand_size_o  = best_r;
  assign used_o       = used_r;
  assign loaded_o     = loaded_r;

endmodule

`default_nettype wire

// File: design/worst_fit_block_allocator.sv
`default_nettype none

// Worst-fit block allocator. Each word on the input channel either adds a
// memory block of the given size to the table (action 0) or requests an
// allocation (action 1), and every input word yields exactly one result word.
// A request is granted the largest unused block, with ties going to the block
// loaded first, provided the request fits; the whole block is then marked used
// and never split. Blocks are held in a row of MAX_BLOCKS cells. A request
// sends a candidate (best block so far) through the row, one cell per clock.
// A request's result is formed at the end of the scan and an add's when the
// add is accepted; either is then held in the done state until it moves into
// the output register, and the input stays stalled until then. One word is
// worked on at a time, but a finished result sits in the output register, so
// the next input word can be accepted while the previous result is still
// stalled. Failed requests still consume a request number, which wraps at
// 16 bits.
module worst_fit_block_allocator #(
  parameter int MAX_BLOCKS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wfba_pkg::wfba_in_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wfba_pkg::wfba_out_t      out_word
);

  import wfba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  wfba_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]     loaded_cnt_r, loaded_cnt_nxt;
  logic [15:0]          req_seen_r, req_seen_nxt;
  logic [SIZE_BITS-1:0] amt_r, amt_nxt;
  wfba_out_t            res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  wfba_out_t            out_word_r, out_word_nxt;

  logic                 in_acc;
  logic                 table_full;
  logic                 add_en;
  logic                 grant_en;
  logic [SIZE_BITS-1:0] in_amt;

  // Candidate chain: entry 0 is the empty candidate fed into the first cell.
  logic                 cf [MAX_BLOCKS+1];
  logic [IDX_W-1:0]     ci [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] cs [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] used_vec;
  logic [MAX_BLOCKS-1:0] loaded_vec;

  assign cf[0] = 1'b0;
  assign ci[0] = '0;
  assign cs[0] = '0;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign table_full = (loaded_cnt_r == CNT_W'(MAX_BLOCKS));
  assign in_amt     = SIZE_BITS'(in_word.amount);

  genvar k;
  generate
    for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      wfba_cell #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS),
        .CELL_IDX  (k)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_en      (add_en && (loaded_cnt_r == CNT_W'(k))),
        .load_size    (in_amt),
        .grant_en     (grant_en && (ci[MAX_BLOCKS] == IDX_W'(k))),
        .cand_found_i (cf[k]),
        .cand_idx_i   (ci[k]),
        .cand_size_i  (cs[k]),
        .cand_found_o (cf[k+1]),
        .cand_idx_o   (ci[k+1]),
        .cand_size_o  (cs[k+1]),
        .used_o       (used_vec[k]),
        .loaded_o     (loaded_vec[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_cnt_r   <= '0;
      loaded_cnt_r <= '0;
      req_seen_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      loaded_cnt_r <= loaded_cnt_nxt;
      req_seen_r   <= req_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_r      <= amt_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    loaded_cnt_nxt = loaded_cnt_r;
    req_seen_nxt   = req_seen_r;
    amt_nxt        = amt_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    add_en         = 1'b0;
    grant_en       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word.action == ACT_ADD) begin
            res_nxt.request_number = '0;
            if (table_full) begin
              res_nxt.outcome      = OUT_FULL;
              res_nxt.block_index  = '0;
              res_nxt.block_amount = '0;
            end else begin
              add_en               = 1'b1;
              res_nxt.outcome      = OUT_ADDED;
              res_nxt.block_index  = 5'(loaded_cnt_r);
              res_nxt.block_amount = 16'(in_amt);
              loaded_cnt_nxt       = loaded_cnt_r + CNT_W'(1);
            end
            state_nxt = ST_DONE;
          end else begin
            res_nxt.request_number = req_seen_r;
            req_seen_nxt           = req_seen_r + 16'd1;
            amt_nxt                = in_amt;
            scan_cnt_nxt           = '0;
            state_nxt              = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // The last cell holds the answer once the candidate has passed all cells.
        if (scan_cnt_r == CNT_W'(MAX_BLOCKS)) begin
          if (cf[MAX_BLOCKS] && (amt_r <= cs[MAX_BLOCKS])) begin
            grant_en             = 1'b1;
            res_nxt.outcome      = OUT_GRANTED;
            res_nxt.block_index  = 5'(ci[MAX_BLOCKS]);
            res_nxt.block_amount = 16'(cs[MAX_BLOCKS]);
          end else begin
            res_nxt.outcome      = OUT_NOFIT;
            res_nxt.block_index  = '0;
            res_nxt.block_amount = '0;
          end
          state_nxt = ST_DONE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_word_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_req_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_word.action == ACT_REQUEST)) |=> (state_r == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_cnt_r <= CNT_W'(MAX_BLOCKS)))
    else $error("scan counter ran past the row of cells");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_cnt_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count exceeds table size");

  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    grant_en |-> (loaded_vec[ci[MAX_BLOCKS]] && !used_vec[ci[MAX_BLOCKS]]))
    else $error("granted block was not a loaded free block");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && (state_r == ST_DONE)) |=> (state_r == ST_DONE))
    else $error("pending result dropped while output was stalled");

endmodule

`default_nettype wire

// File: sim/worst_fit_block_allocator_tb.sv
`default_nettype none

// Self-checking bench for the worst-fit block allocator.
//
// A directed table opens the run and a long stretch of random words follows.
// Every accepted input word is run through a local model of the allocation
// table. The model keeps sizes, used marks, the block count and the request
// counter, and its answer is queued. Each accepted result word is compared,
// field by field, against the oldest queued answer. The request counter wraps
// at 16 bits in the model, but the run is far too short to reach the wrap.
module worst_fit_block_allocator_tb;
  import wfba_pkg::*;

  localparam int NUM_BLOCKS    = 32;
  localparam int SIZE_W        = 16;
  localparam int RANDOM_WORDS  = 880;
  // The random tail is all adds, so the table is sure to overflow.
  localparam int ADD_TAIL      = 40;
  // Long enough to cover the scan of any straggling request.
  localparam int DRAIN_CYCLES  = 2 * (NUM_BLOCKS + 2) + 12;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int HOLD_AFTER    = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_MAX    = 10;

  // One row of the opening table. When has_answer is set, the answer is
  // queued as written and the model runs only to keep its state in step.
  typedef struct packed {
    logic      has_answer;
    wfba_in_t  word;
    wfba_out_t answer;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // A request on an empty table fails. Both extremes of the size are tried.
    '{1'b1, '{ACT_REQUEST, 16'h0000}, '{OUT_NOFIT,   5'd0, 16'h0000, 16'd0}},
    '{1'b1, '{ACT_REQUEST, 16'hFFFF}, '{OUT_NOFIT,   5'd0, 16'h0000, 16'd1}},
    // A block of size zero still takes a request of size zero.
    '{1'b1, '{ACT_ADD,     16'h0000}, '{OUT_ADDED,   5'd0, 16'h0000, 16'd0}},
    '{1'b1, '{ACT_REQUEST, 16'h0000}, '{OUT_GRANTED, 5'd0, 16'h0000, 16'd2}},
    // Every block is in use now, so nothing fits.
    '{1'b1, '{ACT_REQUEST, 16'h0000}, '{OUT_NOFIT,   5'd0, 16'h0000, 16'd3}},
    // Two equal blocks: the one loaded first wins the tie.
    '{1'b1, '{ACT_ADD,     16'hFFFF}, '{OUT_ADDED,   5'd1, 16'hFFFF, 16'd0}},
    '{1'b1, '{ACT_ADD,     16'hFFFF}, '{OUT_ADDED,   5'd2, 16'hFFFF, 16'd0}},
    '{1'b1, '{ACT_REQUEST, 16'hFFFF}, '{OUT_GRANTED, 5'd1, 16'hFFFF, 16'd4}},
    '{1'b1, '{ACT_REQUEST, 16'h8000}, '{OUT_GRANTED, 5'd2, 16'hFFFF, 16'd5}},
    // The largest free block is one short of the request, then an exact fit.
    '{1'b0, '{ACT_ADD,     16'h0064}, '0},
    '{1'b0, '{ACT_ADD,     16'h00C8}, '0},
    '{1'b0, '{ACT_REQUEST, 16'h00C9}, '0},
    '{1'b0, '{ACT_REQUEST, 16'h00C8}, '0},
    // Alternating bit patterns, and a small request that lands on the largest.
    '{1'b0, '{ACT_ADD,     16'h5555}, '0},
    '{1'b0, '{ACT_ADD,     16'hAAAA}, '0},
    '{1'b0, '{ACT_ADD,     16'hAAAA}, '0},
    '{1'b0, '{ACT_REQUEST, 16'h0001}, '0},
    '{1'b0, '{ACT_ADD,     16'h7FFF}, '0},
    '{1'b0, '{ACT_REQUEST, 16'h7FFF}, '0},
    '{1'b0, '{ACT_REQUEST, 16'hFFFF}, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  wfba_in_t  in_word;
  logic      out_valid;
  logic      out_stall;
  wfba_out_t out_word;

  // This is the local model of the allocation table.
  logic [SIZE_W-1:0] block_size_tbl [NUM_BLOCKS];
  logic              block_taken    [NUM_BLOCKS];
  int                blocks_in_table = 0;
  logic [15:0]       requests_issued = '0;

  wfba_out_t   expected_results [$];
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  worst_fit_block_allocator #(
    .MAX_BLOCKS(NUM_BLOCKS),
    .SIZE_BITS (SIZE_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one word to the local table and return the result word it should
  // produce. An add takes the next free slot. A request takes the largest
  // unused block, and the earliest such block when sizes tie.
  function automatic wfba_out_t allocate_worst_fit(input wfba_in_t w);
    wfba_out_t         r;
    bit                found;
    int                best;
    logic [SIZE_W-1:0] best_size;
    r = '0;
    found = 1'b0;
    best = 0;
    best_size = '0;
    if (w.action == ACT_ADD) begin
      if (blocks_in_table >= NUM_BLOCKS) begin
        r.outcome = OUT_FULL;
      end else begin
        block_size_tbl[blocks_in_table] = w.amount[SIZE_W-1:0];
        block_taken[blocks_in_table] = 1'b0;
        r.outcome = OUT_ADDED;
        r.block_index = 5'(blocks_in_table);
        r.block_amount = 16'(w.amount[SIZE_W-1:0]);
        blocks_in_table++;
      end
    end else begin
      r.request_number = requests_issued;
      requests_issued = requests_issued + 16'd1;
      for (int k = 0; k < blocks_in_table; k++) begin
        if (!block_taken[k] && (!found || block_size_tbl[k] > best_size)) begin
          found = 1'b1;
          best = k;
          best_size = block_size_tbl[k];
        end
      end
      if (found && w.amount[SIZE_W-1:0] <= best_size) begin
        block_taken[best] = 1'b1;
        r.outcome = OUT_GRANTED;
        r.block_index = 5'(best);
        r.block_amount = 16'(best_size);
      end else begin
        r.outcome = OUT_NOFIT;
      end
    end
    return r;
  endfunction

  // Most gaps are zero or short. Now and then one runs long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random words are mostly requests, with adds spread thinly so that the
  // table fills slowly. Block sizes often come from a small set so that ties
  // occur. Request sizes mix full-range values, which usually fail and leave
  // blocks free, with small ones that usually succeed.
  function automatic wfba_in_t random_word(input bit add_only);
    wfba_in_t w;
    int       r;
    w.action = (add_only || $urandom_range(0, 99) < 4) ? ACT_ADD : ACT_REQUEST;
    r = $urandom_range(0, 9);
    if (w.action == ACT_ADD) begin
      if (r < 3) begin
        case ($urandom_range(0, 3))
          0:       w.amount = 16'h0000;
          1:       w.amount = 16'h1000;
          2:       w.amount = 16'h8000;
          default: w.amount = 16'hFFFF;
        endcase
      end else begin
        w.amount = 16'($urandom);
      end
    end else begin
      if (r < 4)      w.amount = 16'($urandom);
      else if (r < 7) w.amount = 16'($urandom_range(0, 255));
      else            w.amount = 16'($urandom_range(0, 16'h1000));
    end
    return w;
  endfunction

  task automatic report_failure(input string what);
    if (fail_count < REPORT_MAX) $display("ERROR @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_result(input wfba_out_t got);
    wfba_out_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_failure($sformatf("unexpected result: outcome %0d index %0d size %h req %0d",
                               got.outcome, got.block_index, got.block_amount,
                               got.request_number));
    end else begin
      want = expected_results.pop_front();
      if (got.outcome !== want.outcome || got.block_index !== want.block_index ||
          got.block_amount !== want.block_amount ||
          got.request_number !== want.request_number) begin
        report_failure($sformatf({"result %0d: expected outcome %0d index %0d size %h ",
                                  "req %0d, got outcome %0d index %0d size %h req %0d"},
                                 results_seen, want.outcome, want.block_index,
                                 want.block_amount, want.request_number, got.outcome,
                                 got.block_index, got.block_amount, got.request_number));
      end
    end
  endtask

  // Hold one word on the input until the block takes it, and queue its
  // answer at the edge where it is taken. The valid line stays high into the
  // next word when there is no gap, so it is never dropped and raised in one
  // step.
  task automatic offer_word(input wfba_in_t w, input bit has_answer,
                            input wfba_out_t answer, input int gap);
    wfba_out_t predicted;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = allocate_worst_fit(w);
    expected_results.push_back(has_answer ? answer : predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The input side handles reset, then the directed rows, then the random
  // words, and finally the drain and the verdict.
  initial begin : word_side
    bit sender_calm;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    sender_calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_word(DIRECTED[i].word, DIRECTED[i].has_answer, DIRECTED[i].answer,
                 pick_gap());
    end

    // Calm stretches send back to back. The rest see gaps from pick_gap, zero,
    // short or long, so the gaps land on every phase of a request's scan.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      offer_word(random_word(n >= RANDOM_WORDS - ADD_TAIL), 1'b0, '0,
                 sender_calm ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    // Any late extra result shows up here as an unexpected word.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // The result side checks every word it takes and stalls at random. Once,
  // after a couple hundred results, it holds off for a long stretch while
  // the input side keeps offering. The output register and the scan then
  // both fill, and the block has to stall its input.
  initial begin : result_side
    int unsigned tick;
    int          stall_left;
    int          hold_left;
    bit          receiver_calm;
    bit          hold_done;
    out_stall <= 1'b0;
    tick = 0;
    stall_left = 0;
    hold_left = 0;
    receiver_calm = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        check_result(out_word);
      end
      tick++;
      if (tick % 128 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!receiver_calm && $urandom_range(0, 7) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
        end
      end
    end
  end

  // The watchdog allows several times the slowest legal run: every word
  // waits out the longest input gap, the full scan and the longest stall.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/wfba_pkg.sv
design/wfba_cell.sv
design/worst_fit_block_allocator.sv
sim/worst_fit_block_allocator_tb.sv
